// ===== hdl/uvs_pkg.sv =====
// UV sphere vertex generator: shared package.
// Holds field widths, register codes, the arctangent table and small helpers.
// Depends on nothing.
package uvs_pkg;

	localparam int IDX_W  = 10;
	localparam int CNT_W  = 11;
	localparam int RAD_W  = 16;
	localparam int POS_W  = 17;
	localparam int NRM_W  = 16;
	localparam int TEX_W  = 17;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int ANG_W  = 34;

	// Register codes, taken from the word address.
	localparam logic [1:0] REG_RING   = 2'd0;
	localparam logic [1:0] REG_SECTOR = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	localparam logic [CNT_W-1:0] RING_RESET   = 11'd16;
	localparam logic [CNT_W-1:0] SECTOR_RESET = 11'd32;
	localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd256;

	// Rounded Q30 arctangents of 2^-i.
	localparam int ATAN_ENTRIES = 24;
	localparam logic [29:0] ATAN_Q30 [0:ATAN_ENTRIES-1] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
		30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
		30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
		30'd262144,    30'd131072,    30'd65536,     30'd32768,
		30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128
	};

	localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [31:0]      HALF_PI_Q30     = 32'sd1686629713;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [CNT_W-1:0] ring_count;
		logic [CNT_W-1:0] sector_count;
		logic [RAD_W-1:0] radius;
	} uvs_cfg_t;

	// One classified grid point between front and back.
	typedef struct packed {
		logic [IDX_W-1:0] ring;
		logic [IDX_W-1:0] sector;
		logic             oor;
	} uvs_item_t;

	// Per-stage bookkeeping once the texture coordinates are known.
	typedef struct packed {
		logic             v;
		logic             oor;
		logic [TEX_W-1:0] tu;
		logic [TEX_W-1:0] tv;
	} uvs_meta_t;

	// One restoring division step: returns {quotient bit, new remainder}.
	function automatic logic [CNT_W:0] div_step(input logic [CNT_W-1:0] rem,
			input logic nbit, input logic [CNT_W-1:0] den);
		logic [CNT_W:0] t;
		t = {rem, nbit};
		if (t >= {1'b0, den}) begin
			div_step = {1'b1, CNT_W'(t - {1'b0, den})};
		end else begin
			div_step = {1'b0, t[CNT_W-1:0]};
		end
	endfunction

	// Saturate to a signed Q1.15 value.
	function automatic logic signed [NRM_W-1:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) begin
			sat16 = 16'sh7FFF;
		end else if (v < -64'sd32768) begin
			sat16 = 16'sh8000;
		end else begin
			sat16 = NRM_W'(v);
		end
	endfunction

endpackage

// ===== hdl/uvs_if.sv =====
// UV sphere vertex generator: request and vertex channel interfaces.
// Depends on uvs_pkg for field widths.
interface uvs_in_if;
	import uvs_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] ring_index;
	logic [IDX_W-1:0] sector_index;
	modport source(output valid, ring_index, sector_index, input ready);
	modport sink(input valid, ring_index, sector_index, output ready);
endinterface

interface uvs_out_if;
	import uvs_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic signed [NRM_W-1:0] norm_x;
	logic signed [NRM_W-1:0] norm_y;
	logic signed [NRM_W-1:0] norm_z;
	logic [TEX_W-1:0]        tex_u;
	logic [TEX_W-1:0]        tex_v;
	logic                    out_of_range;
	modport source(output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		tex_u, tex_v, out_of_range, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		tex_u, tex_v, out_of_range, output ready);
endinterface

// ===== hdl/uvs_regs.sv =====
// UV sphere vertex generator: configuration register file on the APB port.
// Depends on uvs_pkg.
module uvs_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [uvs_pkg::ADDR_W-1:0] paddr,
	input  logic [uvs_pkg::DATA_W-1:0] pwdata,
	output logic [uvs_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output uvs_pkg::uvs_cfg_t          cfg
);
	import uvs_pkg::*;

	uvs_cfg_t cfg_q;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Register writes; unknown addresses are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ring_count   <= RING_RESET;
			cfg_q.sector_count <= SECTOR_RESET;
			cfg_q.radius       <= RADIUS_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_RING:   cfg_q.ring_count   <= pwdata[CNT_W-1:0];
				REG_SECTOR: cfg_q.sector_count <= pwdata[CNT_W-1:0];
				REG_RADIUS: cfg_q.radius       <= pwdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		case (paddr[3:2])
			REG_RING:   prdata = DATA_W'(cfg_q.ring_count);
			REG_SECTOR: prdata = DATA_W'(cfg_q.sector_count);
			REG_RADIUS: prdata = DATA_W'(cfg_q.radius);
			default:    prdata = '0;
		endcase
	end
endmodule

// ===== hdl/uvs_front.sv =====
// UV sphere vertex generator: front end that accepts a grid point and classifies it.
// Depends on uvs_pkg and uvs_in_if.
module uvs_front #(
	parameter int GRID_INDEX_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	uvs_in_if.sink               grid,
	input  uvs_pkg::uvs_cfg_t    cfg,
	output logic                 q_valid,
	output uvs_pkg::uvs_item_t   q_item,
	input  logic                 q_ready
);
	import uvs_pkg::*;

	localparam int MASK_BITS = (GRID_INDEX_BITS < IDX_W) ? GRID_INDEX_BITS : IDX_W;
	localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((64'd1 << MASK_BITS) - 64'd1);

	logic             v_s1;
	uvs_item_t        item_s1;
	logic [IDX_W-1:0] ring_m;
	logic [IDX_W-1:0] sector_m;
	logic             oor;

	assign grid.ready = !v_s1 || q_ready;
	assign q_valid    = v_s1;
	assign q_item     = item_s1;

	// Mask the indices and decide whether the point lies on the grid.
	always_comb begin
		ring_m   = grid.ring_index & IDX_MASK;
		sector_m = grid.sector_index & IDX_MASK;
		oor = (cfg.ring_count < CNT_W'(2)) || (cfg.sector_count < CNT_W'(2))
			|| ({1'b0, ring_m} >= cfg.ring_count)
			|| ({1'b0, sector_m} >= cfg.sector_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (grid.ready) begin
			v_s1 <= grid.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (grid.ready && grid.valid) begin
			item_s1 <= '{ring: ring_m, sector: sector_m, oor: oor};
		end
	end
endmodule

// ===== hdl/uvs_queue.sv =====
// UV sphere vertex generator: two-entry queue between front and back.
// Depends on uvs_pkg.
module uvs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	input  uvs_pkg::uvs_item_t wr_item,
	output logic               wr_ready,
	output logic               rd_valid,
	output uvs_pkg::uvs_item_t rd_item,
	input  logic               rd_ready
);
	import uvs_pkg::*;

	uvs_item_t  mem [0:1];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_item  = mem[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule

// ===== hdl/uvs_back.sv =====
// UV sphere vertex generator: back end pipeline (dividers, angle folding, CORDIC,
// normal and position products, output register). Depends on uvs_pkg and uvs_out_if.
module uvs_back #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  uvs_pkg::uvs_cfg_t  cfg,
	input  logic               q_valid,
	input  uvs_pkg::uvs_item_t q_item,
	output logic               q_ready,
	uvs_out_if.source          vertex
);
	import uvs_pkg::*;

	localparam int ITER = TRIG_ITERATIONS;

	logic             adv;
	logic             out_v_q;
	logic [CNT_W-1:0] den_u;
	logic [CNT_W-1:0] den_v;

	// The whole pipeline moves unless the output register holds a vertex not taken.
	assign adv     = !out_v_q || vertex.ready;
	assign q_ready = adv;
	assign den_u   = cfg.sector_count - CNT_W'(1);
	assign den_v   = cfg.ring_count - CNT_W'(1);

	// ---------------- texture coordinate dividers ----------------
	logic             dv_v   [0:TEX_W];
	logic             dv_o   [0:TEX_W];
	logic [CNT_W-1:0] rem_u  [0:TEX_W];
	logic [CNT_W-1:0] rem_v  [0:TEX_W];
	logic [TEX_W-1:0] num_u  [0:TEX_W];
	logic [TEX_W-1:0] num_v  [0:TEX_W];
	logic [TEX_W-1:0] quo_u  [0:TEX_W];
	logic [TEX_W-1:0] quo_v  [0:TEX_W];

	// Numerator is index * 65536 + half the divisor; its top bits start the remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (adv) begin
			dv_v[0] <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_o[0]  <= q_item.oor;
			rem_u[0] <= CNT_W'(q_item.sector[IDX_W-1:1]);
			rem_v[0] <= CNT_W'(q_item.ring[IDX_W-1:1]);
			num_u[0] <= {q_item.sector[0], 16'(den_u[CNT_W-1:1])};
			num_v[0] <= {q_item.ring[0], 16'(den_v[CNT_W-1:1])};
			quo_u[0] <= '0;
			quo_v[0] <= '0;
		end
	end

	for (genvar k = 0; k < TEX_W; k++) begin : g_div
		logic [CNT_W:0] st_u;
		logic [CNT_W:0] st_v;

		assign st_u = div_step(rem_u[k], num_u[k][TEX_W-1], den_u);
		assign st_v = div_step(rem_v[k], num_v[k][TEX_W-1], den_v);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else if (adv) begin
				dv_v[k+1] <= dv_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_o[k+1]  <= dv_o[k];
				rem_u[k+1] <= st_u[CNT_W-1:0];
				rem_v[k+1] <= st_v[CNT_W-1:0];
				num_u[k+1] <= {num_u[k][TEX_W-2:0], 1'b0};
				num_v[k+1] <= {num_v[k][TEX_W-2:0], 1'b0};
				quo_u[k+1] <= {quo_u[k][TEX_W-2:0], st_u[CNT_W]};
				quo_v[k+1] <= {quo_v[k][TEX_W-2:0], st_v[CNT_W]};
			end
		end
	end

	// ---------------- angle folding ----------------
	// Unit 0 works on theta (ring), unit 1 on phi (sector).
	logic [31:0]        turn     [0:1];
	logic [31:0]        turn_off [0:1];
	logic [1:0]         quad_s1  [0:1];
	logic signed [31:0] rad_s1   [0:1];
	logic [1:0]         quad_s2  [0:1];
	logic signed [63:0] prod_s2  [0:1];
	uvs_meta_t          meta_s1;
	uvs_meta_t          meta_s2;

	assign turn[0] = {quo_v[TEX_W], 15'b0};
	assign turn[1] = {quo_u[TEX_W][15:0], 16'b0};

	for (genvar j = 0; j < 2; j++) begin : g_fold
		assign turn_off[j] = turn[j] + 32'h2000_0000;

		// Nearest quarter turn and the signed remainder around it.
		always_ff @(posedge clk) begin
			if (adv) begin
				quad_s1[j] <= turn_off[j][31:30];
				rad_s1[j]  <= $signed(turn[j] - {turn_off[j][31:30], 30'b0});
				quad_s2[j] <= quad_s1[j];
				prod_s2[j] <= 64'(rad_s1[j]) * 64'(HALF_PI_Q30);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
		end else if (adv) begin
			meta_s1 <= '{v: dv_v[TEX_W], oor: dv_o[TEX_W], tu: quo_u[TEX_W],
				tv: quo_v[TEX_W]};
			meta_s2 <= meta_s1;
		end
	end

	// ---------------- CORDIC rotation ----------------
	logic signed [ANG_W-1:0] cx [0:ITER][0:1];
	logic signed [ANG_W-1:0] cy [0:ITER][0:1];
	logic signed [ANG_W-1:0] cz [0:ITER][0:1];
	logic [1:0]              cq [0:ITER][0:1];
	uvs_meta_t               cm [0:ITER];

	for (genvar j = 0; j < 2; j++) begin : g_cinit
		logic signed [63:0] zr;
		assign zr = (prod_s2[j] + 64'sd536870912) >>> 30;

		always_ff @(posedge clk) begin
			if (adv) begin
				cx[0][j] <= CORDIC_GAIN_Q30;
				cy[0][j] <= '0;
				cz[0][j] <= ANG_W'(zr);
				cq[0][j] <= quad_s2[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cm[0] <= '0;
		end else if (adv) begin
			cm[0] <= meta_s2;
		end
	end

	for (genvar i = 0; i < ITER; i++) begin : g_iter
		localparam logic signed [ANG_W-1:0] ATAN_I = $signed({4'b0, ATAN_Q30[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cm[i+1] <= '0;
			end else if (adv) begin
				cm[i+1] <= cm[i];
			end
		end

		for (genvar j = 0; j < 2; j++) begin : g_unit
			// Rotate toward zero residual angle.
			always_ff @(posedge clk) begin
				if (adv) begin
					cq[i+1][j] <= cq[i][j];
					if (!cz[i][j][ANG_W-1]) begin
						cx[i+1][j] <= cx[i][j] - (cy[i][j] >>> i);
						cy[i+1][j] <= cy[i][j] + (cx[i][j] >>> i);
						cz[i+1][j] <= cz[i][j] - ATAN_I;
					end else begin
						cx[i+1][j] <= cx[i][j] + (cy[i][j] >>> i);
						cy[i+1][j] <= cy[i][j] - (cx[i][j] >>> i);
						cz[i+1][j] <= cz[i][j] + ATAN_I;
					end
				end
			end
		end
	end

	// ---------------- quadrant restore ----------------
	logic signed [31:0] cos_m1 [0:1];
	logic signed [31:0] sin_m1 [0:1];
	uvs_meta_t          meta_m1;

	for (genvar j = 0; j < 2; j++) begin : g_quad
		always_ff @(posedge clk) begin
			if (adv) begin
				case (cq[ITER][j])
					2'd0: begin
						cos_m1[j] <= 32'(cx[ITER][j]);
						sin_m1[j] <= 32'(cy[ITER][j]);
					end
					2'd1: begin
						cos_m1[j] <= 32'(-cy[ITER][j]);
						sin_m1[j] <= 32'(cx[ITER][j]);
					end
					2'd2: begin
						cos_m1[j] <= 32'(-cx[ITER][j]);
						sin_m1[j] <= 32'(-cy[ITER][j]);
					end
					default: begin
						cos_m1[j] <= 32'(cy[ITER][j]);
						sin_m1[j] <= 32'(-cx[ITER][j]);
					end
				endcase
			end
		end
	end

	// ---------------- normal products ----------------
	logic signed [63:0] px_m2;
	logic signed [63:0] pz_m2;
	logic signed [31:0] ct_m2;
	uvs_meta_t          meta_m2;
	logic signed [NRM_W-1:0] nx_m3;
	logic signed [NRM_W-1:0] ny_m3;
	logic signed [NRM_W-1:0] nz_m3;
	uvs_meta_t          meta_m3;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_m2 <= 64'(cos_m1[1]) * 64'(sin_m1[0]);
			pz_m2 <= 64'(sin_m1[1]) * 64'(sin_m1[0]);
			ct_m2 <= cos_m1[0];
			nx_m3 <= sat16((px_m2 + 64'sh1000_0000_0000) >>> 45);
			nz_m3 <= sat16((pz_m2 + 64'sh1000_0000_0000) >>> 45);
			ny_m3 <= sat16((-64'(ct_m2) + 64'sd16384) >>> 15);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_m1 <= '0;
			meta_m2 <= '0;
			meta_m3 <= '0;
		end else if (adv) begin
			meta_m1 <= cm[ITER];
			meta_m2 <= meta_m1;
			meta_m3 <= meta_m2;
		end
	end

	// ---------------- position scaling and output register ----------------
	logic signed [RAD_W:0]   rad_s;
	logic signed [39:0]      sx;
	logic signed [39:0]      sy;
	logic signed [39:0]      sz;
	logic signed [POS_W-1:0] pos_x_q;
	logic signed [POS_W-1:0] pos_y_q;
	logic signed [POS_W-1:0] pos_z_q;
	logic signed [NRM_W-1:0] norm_x_q;
	logic signed [NRM_W-1:0] norm_y_q;
	logic signed [NRM_W-1:0] norm_z_q;
	logic [TEX_W-1:0]        tex_u_q;
	logic [TEX_W-1:0]        tex_v_q;
	logic                    oor_q;

	assign rad_s = $signed({1'b0, cfg.radius});
	assign sx = (40'(nx_m3) * 40'(rad_s) + 40'sd16384) >>> 15;
	assign sy = (40'(ny_m3) * 40'(rad_s) + 40'sd16384) >>> 15;
	assign sz = (40'(nz_m3) * 40'(rad_s) + 40'sd16384) >>> 15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= meta_m3.v;
		end
	end

	// Points off the grid report only the flag.
	always_ff @(posedge clk) begin
		if (adv) begin
			oor_q <= meta_m3.oor;
			if (meta_m3.oor) begin
				pos_x_q  <= '0;
				pos_y_q  <= '0;
				pos_z_q  <= '0;
				norm_x_q <= '0;
				norm_y_q <= '0;
				norm_z_q <= '0;
				tex_u_q  <= '0;
				tex_v_q  <= '0;
			end else begin
				pos_x_q  <= POS_W'(sx);
				pos_y_q  <= POS_W'(sy);
				pos_z_q  <= POS_W'(sz);
				norm_x_q <= nx_m3;
				norm_y_q <= ny_m3;
				norm_z_q <= nz_m3;
				tex_u_q  <= meta_m3.tu;
				tex_v_q  <= meta_m3.tv;
			end
		end
	end

	assign vertex.valid        = out_v_q;
	assign vertex.pos_x        = pos_x_q;
	assign vertex.pos_y        = pos_y_q;
	assign vertex.pos_z        = pos_z_q;
	assign vertex.norm_x       = norm_x_q;
	assign vertex.norm_y       = norm_y_q;
	assign vertex.norm_z       = norm_z_q;
	assign vertex.tex_u        = tex_u_q;
	assign vertex.tex_v        = tex_v_q;
	assign vertex.out_of_range = oor_q;
endmodule

// ===== hdl/uv_sphere_vertex_generator.sv =====
// UV sphere vertex generator, top level.
// Throughput: one request per cycle while the vertex channel takes each vertex;
// the 17-stage dividers and the CORDIC stages are fully pipelined, so the rate
// is set by the single pipeline advance.
// Reset: ring_count 16, sector_count 32, radius 256; all pipeline and queue
// entries are emptied. Depends on uvs_pkg, the interfaces and the submodules.
module uv_sphere_vertex_generator #(
	parameter int GRID_INDEX_BITS = 10,
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [uvs_pkg::ADDR_W-1:0] paddr,
	input  logic [uvs_pkg::DATA_W-1:0] pwdata,
	output logic [uvs_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	uvs_in_if.sink                     grid,
	uvs_out_if.source                  vertex
);
	import uvs_pkg::*;

	uvs_cfg_t  cfg;
	logic      f_valid;
	uvs_item_t f_item;
	logic      f_ready;
	logic      b_valid;
	uvs_item_t b_item;
	logic      b_ready;

	// Configuration registers.
	uvs_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	// Request intake and classification.
	uvs_front #(.GRID_INDEX_BITS(GRID_INDEX_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .grid(grid), .cfg(cfg),
		.q_valid(f_valid), .q_item(f_item), .q_ready(f_ready)
	);

	// Decoupling queue.
	uvs_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_item(f_item),
		.wr_ready(f_ready), .rd_valid(b_valid), .rd_item(b_item), .rd_ready(b_ready)
	);

	// Vertex computation.
	uvs_back #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .q_valid(b_valid), .q_item(b_item),
		.q_ready(b_ready), .vertex(vertex)
	);
endmodule

// ===== tb/uvs_checker.sv =====
// Vertex checker for the UV sphere vertex generator testbench.
// Watches the register port and both channels, predicts every vertex and compares.
// Depends on uvs_pkg and the channel interfaces.
`timescale 1ns / 100ps

module uvs_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [uvs_pkg::ADDR_W-1:0] paddr,
	input  logic [uvs_pkg::DATA_W-1:0] pwdata,
	input  logic                       pready,
	uvs_in_if                          grid,
	uvs_out_if                         vertex,
	output int                         fail_count,
	output int                         pending
);
	import uvs_pkg::*;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [NRM_W-1:0] norm_x;
		logic signed [NRM_W-1:0] norm_y;
		logic signed [NRM_W-1:0] norm_z;
		logic [TEX_W-1:0]        tex_u;
		logic [TEX_W-1:0]        tex_v;
		logic                    out_of_range;
	} vertex_t;

	localparam int TRIG_STEPS = 16;

	logic [CNT_W-1:0] ring_cfg;
	logic [CNT_W-1:0] sector_cfg;
	logic [RAD_W-1:0] radius_cfg;
	vertex_t          vertex_fifo[$];

	// Cosine and sine in Q30 of an angle held as a fraction of a full turn.
	function automatic void turn_sincos(input logic [31:0] t, output longint c,
			output longint s);
		logic [31:0] q;
		logic [31:0] d;
		longint      r, z, x, y, xs, ys;
		q = ((t + 32'h2000_0000) >> 30) & 32'd3;
		d = t - (q << 30);
		r = longint'({32'd0, d});
		if (d[31]) begin
			r = r - 64'sh1_0000_0000;
		end
		z = (r * longint'(HALF_PI_Q30) + (64'sd1 <<< 29)) >>> 30;
		x = longint'(CORDIC_GAIN_Q30);
		y = 0;
		for (int i = 0; i < TRIG_STEPS && i < ATAN_ENTRIES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - longint'({34'd0, ATAN_Q30[i]});
			end else begin
				x = x + ys; y = y - xs; z = z + longint'({34'd0, ATAN_Q30[i]});
			end
		end
		case (q[1:0])
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic longint clamp_q15(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Expected vertex for one grid point under the current configuration.
	function automatic vertex_t grid_vertex(input logic [IDX_W-1:0] ring,
			input logic [IDX_W-1:0] sector);
		vertex_t vx;
		longint  rc, sc, tv, tu, ct, st, cp, sp;
		longint  nrm [3];
		longint  p;
		vx = '0;
		rc = ring_cfg;
		sc = sector_cfg;
		if (rc < 2 || sc < 2 || ring >= rc || sector >= sc) begin
			vx.out_of_range = 1'b1;
			return vx;
		end
		tv = (longint'(ring) * 65536 + (rc - 1) / 2) / (rc - 1);
		tu = (longint'(sector) * 65536 + (sc - 1) / 2) / (sc - 1);
		turn_sincos(32'(tv << 15), ct, st);
		turn_sincos(32'(tu << 16), cp, sp);
		nrm[0] = clamp_q15((cp * st + (64'sd1 <<< 44)) >>> 45);
		nrm[1] = clamp_q15((-ct + (64'sd1 <<< 14)) >>> 15);
		nrm[2] = clamp_q15((sp * st + (64'sd1 <<< 44)) >>> 45);
		p = (nrm[0] * longint'(radius_cfg) + (64'sd1 <<< 14)) >>> 15;
		vx.pos_x = POS_W'(p);
		p = (nrm[1] * longint'(radius_cfg) + (64'sd1 <<< 14)) >>> 15;
		vx.pos_y = POS_W'(p);
		p = (nrm[2] * longint'(radius_cfg) + (64'sd1 <<< 14)) >>> 15;
		vx.pos_z = POS_W'(p);
		vx.norm_x = NRM_W'(nrm[0]);
		vx.norm_y = NRM_W'(nrm[1]);
		vx.norm_z = NRM_W'(nrm[2]);
		vx.tex_u = TEX_W'(tu);
		vx.tex_v = TEX_W'(tv);
		return vx;
	endfunction

	task automatic report_mismatch(input string what, input longint got,
			input longint want);
		$display("%0t: vertex mismatch on %s: got %0d, expected %0d", $time, what, got,
			want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Track register writes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_cfg   <= RING_RESET;
			sector_cfg <= SECTOR_RESET;
			radius_cfg <= RADIUS_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_RING:   ring_cfg   <= pwdata[CNT_W-1:0];
				REG_SECTOR: sector_cfg <= pwdata[CNT_W-1:0];
				REG_RADIUS: radius_cfg <= pwdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// Predict on each accepted request and compare each accepted vertex.
	always @(posedge clk) begin
		vertex_t want;
		if (arst_n && grid.valid && grid.ready) begin
			vertex_fifo.push_back(grid_vertex(grid.ring_index, grid.sector_index));
		end
		if (arst_n && vertex.valid && vertex.ready) begin
			if (vertex_fifo.size() == 0) begin
				report_mismatch("vertex count", 1, 0);
			end else begin
				want = vertex_fifo.pop_front();
				if (vertex.pos_x !== want.pos_x)
					report_mismatch("pos_x", vertex.pos_x, want.pos_x);
				if (vertex.pos_y !== want.pos_y)
					report_mismatch("pos_y", vertex.pos_y, want.pos_y);
				if (vertex.pos_z !== want.pos_z)
					report_mismatch("pos_z", vertex.pos_z, want.pos_z);
				if (vertex.norm_x !== want.norm_x)
					report_mismatch("norm_x", vertex.norm_x, want.norm_x);
				if (vertex.norm_y !== want.norm_y)
					report_mismatch("norm_y", vertex.norm_y, want.norm_y);
				if (vertex.norm_z !== want.norm_z)
					report_mismatch("norm_z", vertex.norm_z, want.norm_z);
				if (vertex.tex_u !== want.tex_u)
					report_mismatch("tex_u", vertex.tex_u, want.tex_u);
				if (vertex.tex_v !== want.tex_v)
					report_mismatch("tex_v", vertex.tex_v, want.tex_v);
				if (vertex.out_of_range !== want.out_of_range)
					report_mismatch("out_of_range", vertex.out_of_range,
						want.out_of_range);
			end
		end
		pending = vertex_fifo.size();
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the UV sphere vertex generator testbench: clock, reset, stimulus, verdict.
// Depends on uvs_pkg, the channel interfaces, uvs_checker and the generator.
`timescale 1ns / 100ps

module tb_top;
	import uvs_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASES = 9;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              calm;
	int                fail_count;
	int                pending;
	int                stall_cycles;
	int                rc, sc;

	uvs_in_if  grid();
	uvs_out_if vertex();

	uv_sphere_vertex_generator u_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.grid(grid), .vertex(vertex)
	);

	uvs_checker u_checker (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready), .grid(grid),
		.vertex(vertex), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Register write: setup cycle, then access until pready.
	task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = ADDR_W'({idx, 2'b00}); pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	// One grid request, with a random gap before it unless the run is calm.
	task automatic send_point(input int ring, input int sector);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			grid.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		grid.valid = 1'b1;
		grid.ring_index = IDX_W'(ring);
		grid.sector_index = IDX_W'(sector);
		do @(posedge clk); while (!grid.ready);
		@(negedge clk);
	endtask

	// Idle the request side until every vertex is back.
	task automatic drain();
		grid.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic int pick_index(input int count);
		if (count >= 2 && count <= 1024 && $urandom_range(0, 9) != 0)
			return $urandom_range(0, count - 1);
		return $urandom_range(0, 1023);
	endfunction

	// Vertex receiver: random stall bursts, none once the run is calm.
	initial begin
		vertex.ready = 1'b0;
		@(negedge clk);
		forever begin
			vertex.ready = 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
			if (!calm) begin
				vertex.ready = 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
		end
	end

	// Watchdog on cycles with no accepted transfer of any kind.
	always @(posedge clk) begin
		if ((grid.valid && grid.ready) || (vertex.valid && vertex.ready) ||
				(psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("uv_sphere_vertex_generator verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int ring_set   [PHASES];
		int sector_set [PHASES];
		int radius_set [PHASES];
		stall_cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		grid.valid = 1'b0; grid.ring_index = '0; grid.sector_index = '0;
		// Reset settings first, then extremes, degenerate grids, a random grid and a small one.
		ring_set   = '{16, 2, 1024, 0, 5, 2047, 1, 0, 3};
		sector_set = '{32, 2, 1024, 7, 1, 2047, 9, 0, 4};
		radius_set = '{256, 0, 65535, 300, 1, 65535, 128, 0, 1000};
		ring_set[7]   = $urandom_range(2, 1024);
		sector_set[7] = $urandom_range(2, 1024);
		radius_set[7] = $urandom_range(0, 65535);
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				reg_write(REG_RING, DATA_W'(ring_set[ph]));
				reg_write(REG_SECTOR, DATA_W'(sector_set[ph]));
				reg_write(REG_RADIUS, DATA_W'(radius_set[ph]));
				// A write to an unmapped register must change nothing.
				reg_write(REG_UNUSED, DATA_W'($urandom));
			end
			rc = ring_set[ph];
			sc = sector_set[ph];
			calm = (ph == PHASES - 1);
			// Corners, poles, seams and points just off the grid.
			send_point(0, 0);
			send_point(rc - 1, sc - 1);
			send_point(0, sc - 1);
			send_point(rc - 1, 0);
			send_point(rc, 0);
			send_point(0, sc);
			send_point(1023, 1023);
			send_point(rc / 2, sc / 2);
			send_point(rc / 2, sc / 4);
			for (int n = 0; n < 220; n++) begin
				send_point(pick_index(rc), pick_index(sc));
			end
			drain();
		end
		if (fail_count == 0) begin
			$display("uv_sphere_vertex_generator verification clean");
		end else begin
			$display("uv_sphere_vertex_generator verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/uvs_pkg.sv
hdl/uvs_if.sv
hdl/uvs_regs.sv
hdl/uvs_front.sv
hdl/uvs_queue.sv
hdl/uvs_back.sv
hdl/uv_sphere_vertex_generator.sv
tb/uvs_checker.sv
tb/tb_top.sv
